>>> sv/assert_macros.svh
// Assertion helpers, clocked on clk and quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge.
`define AST_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold on the edge after ante.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lkv_pkg.sv
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W       = 5;
  localparam int PADDR_W     = 3;

  localparam logic [0:0] REG_ACTIVE_ENTRIES = 1'b0;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_data;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic signed [31:0] data;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic kill;
  } cell_ctl_t;

  // Zero acts as one, anything past the store saturates.
  function automatic logic [CNT_W-1:0] cap_of(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] c;
    if (v == '0) begin
      c = CNT_W'(1);
    end else if (32'(v) > MAX_ENTRIES) begin
      c = CNT_W'(MAX_ENTRIES);
    end else begin
      c = CNT_W'(v);
    end
    return c;
  endfunction

endpackage

>>> sv/lkv_cell.sv
module lkv_cell (
  input  logic               clk,
  input  logic               rst,
  input  lkv_pkg::entry_t    prev,
  input  lkv_pkg::cell_ctl_t ctl,
  input  logic signed [31:0] probe,
  output lkv_pkg::entry_t    entry,
  output logic               match
);
  import lkv_pkg::*;

  logic               valid;
  logic signed [31:0] key;
  logic signed [31:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.kill) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key  <= prev.key;
      data <= prev.data;
    end
  end

  assign entry = '{valid: valid, key: key, data: data};
  assign match = valid && (key == probe);

endmodule

>>> sv/lru_key_value_cache.sv
// LRU key/value cache, 16 entries, fully associative. A word is taken when
// start is high and busy is low; busy then stays high in the RUN state, and
// the result is on result with result_valid high for exactly one cycle right
// after it; busy is low again then, so a new word can be taken. The receiver
// cannot stall: result must be taken in that cycle. Entries sit in a chain of
// cells ordered by recency (cell 0 most recent); in the cycle after acceptance
// every cell compares its key, and one shift step of the chain moves the
// touched or new entry to the head. A capacity write (active_entries, 0 acts
// as 1, above 16 as 16; a read returns the value as written) drops the least
// recent entries beyond the new capacity at once.
module lru_key_value_cache (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  lkv_pkg::req_t               request,
  output logic                        result_valid,
  output lkv_pkg::res_t               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lkv_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t             state;
  req_t               req;
  logic [CFG_W-1:0]   active_entries;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   cap_now;
  logic [CNT_W-1:0]   cap_new;
  logic               cfg_wr;

  entry_t             cells   [MAX_ENTRIES];
  entry_t             chain_in[MAX_ENTRIES];
  cell_ctl_t          ctl     [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] valid_vec;

  logic               any_hit;
  logic [IDX_W-1:0]   hit_pos;
  logic signed [31:0] hit_data;
  logic [IDX_W-1:0]   lim;
  logic               do_op;
  logic               is_write;
  logic               has_room;
  entry_t             head;

  assign pready  = 1'b1;
  assign prdata  = 32'(active_entries);
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[PADDR_W-1:2] == REG_ACTIVE_ENTRIES);
  assign cap_now = cap_of(active_entries);
  assign cap_new = cap_of(pwdata[CFG_W-1:0]);

  always_comb begin
    hit_pos  = '0;
    hit_data = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
    // keys are unique, so at most one cell matches
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        hit_data = hit_data | cells[i].data;
      end
    end
  end

  assign any_hit  = |match;
  assign is_write = (req.kind == KIND_WRITE);
  assign has_room = (fill_count < cap_now);
  assign do_op    = (state == RUN) && (any_hit || is_write);

  // last cell that takes from its neighbor
  always_comb begin
    if (any_hit) begin
      lim = hit_pos;
    end else if (has_room) begin
      lim = fill_count[IDX_W-1:0];
    end else begin
      lim = IDX_W'(fill_count - CNT_W'(1));
    end
  end

  always_comb begin
    head.valid = 1'b1;
    head.key   = req.lookup_key;
    head.data  = is_write ? req.write_data : hit_data;
  end

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign chain_in[j] = head;
      assign ctl[j].shift = do_op;
    end else begin : g_body
      assign chain_in[j] = cells[j-1];
      assign ctl[j].shift = do_op && (IDX_W'(j) <= lim);
    end
    assign ctl[j].kill = cfg_wr && (CNT_W'(j) >= cap_new);
    assign valid_vec[j] = cells[j].valid;

    lkv_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .prev  (chain_in[j]),
      .ctl   (ctl[j]),
      .probe (req.lookup_key),
      .entry (cells[j]),
      .match (match[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      busy           <= 1'b0;
      result_valid   <= 1'b0;
      fill_count     <= '0;
      active_entries <= CFG_W'(MAX_ENTRIES);
    end else begin
      if (cfg_wr) begin
        active_entries <= pwdata[CFG_W-1:0];
        if (fill_count > cap_new) begin
          fill_count <= cap_new;
        end
      end
      unique case (state)
        IDLE: begin
          result_valid <= 1'b0;
          if (start) begin
            state <= RUN;
            busy  <= 1'b1;
            req   <= request;
          end
        end
        RUN: begin
          state          <= IDLE;
          busy           <= 1'b0;
          result_valid   <= 1'b1;
          result.hit     <= any_hit;
          if (is_write) begin
            result.read_data <= '0;
          end else if (any_hit) begin
            result.read_data <= hit_data;
          end else begin
            result.read_data <= '1;
          end
          if (is_write && !any_hit && has_room) begin
            fill_count <= fill_count + CNT_W'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `AST_ALWAYS(a_fill_cap, fill_count <= cap_now, "fill count above capacity")
  `AST_ALWAYS(a_fill_valid, $countones(valid_vec) == fill_count, "fill count off")
  `AST_ALWAYS(a_strobe_idle, !(result_valid && busy), "result while busy")
  `AST_NEXT(a_accept_busy, start && !busy, busy && !result_valid, "accept not taken")

endmodule

>>> tb/sv/lkv_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels of the LRU cache, keeps
// its own copy of the store and checks every result word in order.
module lkv_checker
  import lkv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  req_t               request,
  input  logic               result_valid,
  input  res_t               result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 outstanding
);

  logic              ent_valid [MAX_ENTRIES];
  logic [31:0]       ent_key   [MAX_ENTRIES];
  logic [31:0]       ent_data  [MAX_ENTRIES];
  int                ent_rank  [MAX_ENTRIES];
  int                fill;
  logic [CFG_W-1:0]  active_cfg;
  res_t              replies_due [$];
  int                fail_count = 0;

  function automatic int cap_now();
    int c;
    c = int'(active_cfg);
    if (c == 0) c = 1;
    if (c > MAX_ENTRIES) c = MAX_ENTRIES;
    return c;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_data[i]  = '0;
      ent_rank[i]  = 0;
    end
    fill       = 0;
    active_cfg = CFG_W'(MAX_ENTRIES);
  endfunction

  // Move slot s to the head; entries that were ahead of it drop one place.
  // A slot that was empty counts as behind everything.
  function automatic void promote(int s, bit was_valid);
    int r;
    r = was_valid ? ent_rank[s] : MAX_ENTRIES;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (ent_valid[i] && i != s && ent_rank[i] < r) ent_rank[i]++;
    ent_rank[s] = 0;
  endfunction

  function automatic void set_active(logic [CFG_W-1:0] v);
    int cap;
    active_cfg = v;
    cap = cap_now();
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (ent_valid[i] && ent_rank[i] >= cap) ent_valid[i] = 1'b0;
    if (fill > cap) fill = cap;
  endfunction

  function automatic res_t lru_access(req_t w);
    res_t r;
    int   slot;
    int   cap;
    int   worst;
    bit   found;
    bit   spare;
    bit   any;
    slot  = 0;
    found = 1'b0;
    spare = 1'b0;
    any   = 1'b0;
    worst = 0;
    cap   = cap_now();
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (!found && ent_valid[i] && ent_key[i] == w.lookup_key) begin
        found = 1'b1;
        slot  = i;
      end
    if (w.kind == KIND_LOOKUP) begin
      if (found) begin
        promote(slot, 1'b1);
        r.hit       = 1'b1;
        r.read_data = ent_data[slot];
      end else begin
        r.hit       = 1'b0;
        r.read_data = '1;
      end
      return r;
    end
    if (found) begin
      ent_data[slot] = w.write_data;
      promote(slot, 1'b1);
    end else begin
      if (fill < cap)
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (!spare && !ent_valid[i]) begin
            spare = 1'b1;
            slot  = i;
          end
      if (spare) begin
        promote(slot, 1'b0);
        ent_valid[slot] = 1'b1;
        fill++;
      end else begin
        // full: the oldest entry gives up its slot
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (ent_valid[i] && (!any || ent_rank[i] > worst)) begin
            any   = 1'b1;
            worst = ent_rank[i];
            slot  = i;
          end
        promote(slot, any);
        if (!any) begin
          ent_valid[slot] = 1'b1;
          fill = 1;
        end
      end
      ent_key[slot]  = w.lookup_key;
      ent_data[slot] = w.write_data;
    end
    r.hit       = found;
    r.read_data = '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      clear_store();
      replies_due.delete();
    end else begin
      if (result_valid) begin
        if (replies_due.size() == 0) begin
          $error("result word with none expected: hit=%0d read_data=%0d",
                 result.hit, result.read_data);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (result.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, result.hit);
            fail_count++;
          end
          if (result.read_data !== want.read_data) begin
            $error("read_data: expected %0d, actual %0d", want.read_data,
                   result.read_data);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_ACTIVE_ENTRIES)
        set_active(pwdata[CFG_W-1:0]);
      if (start && !busy) replies_due.push_back(lru_access(request));
    end
    errors      <= fail_count;
    outstanding <= replies_due.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_KEYS   = 40;
  localparam int PHASE_WORDS = 125;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  req_t               request = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic               busy;
  logic               result_valid;
  res_t               result;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 outstanding;
  int                 cycles = 0;
  logic [31:0]        key_pool [POOL_KEYS];
  bit                 steady = 1'b0;

  lru_key_value_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  lkv_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result_valid(result_valid), .result(result), .psel(psel),
    .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .errors(errors), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic req_t make_word(logic k, logic [31:0] key, logic [31:0] data);
    req_t w;
    w.kind       = k;
    w.lookup_key = key;
    w.write_data = data;
    return w;
  endfunction

  // start stays high across back-to-back words
  task automatic send_word(input req_t w);
    int g;
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] a, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper bits of the word are random; only the low field counts
  task automatic set_capacity(input logic [CFG_W-1:0] c);
    logic [31:0] v;
    v = $urandom();
    v[CFG_W-1:0] = c;
    drain();
    reg_write({REG_ACTIVE_ENTRIES, 2'b00}, v);
  endtask

  task automatic lookup(input logic [31:0] key);
    send_word(make_word(KIND_LOOKUP, key, $urandom()));
  endtask

  task automatic store(input logic [31:0] key, input logic [31:0] data);
    send_word(make_word(KIND_WRITE, key, data));
  endtask

  // mostly keys from a window a bit wider than the capacity, so hits,
  // updates and evictions all happen; the rest are random keys
  task automatic run_phase(input int cap);
    int   window;
    logic k;
    logic [31:0] key;
    window = cap + $urandom_range(1, cap + 2);
    if (window > POOL_KEYS) window = POOL_KEYS;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      k   = $urandom_range(0, 1) ? KIND_WRITE : KIND_LOOKUP;
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, window - 1)]
                                          : $urandom();
      send_word(make_word(k, key, $urandom()));
    end
    steady = 1'b0;
  endtask

  logic [CFG_W-1:0] settings [12] = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16,
                                      5'd2, 5'd8, 5'd3, 5'd16, 5'd12, 5'd4};

  initial begin
    int eff;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_KEYS; i++) key_pool[i] = $urandom();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, extremes of key and data, update of a present key
    lookup(32'h0);
    store(32'h8000_0000, 32'h7fff_ffff);
    store(32'h7fff_ffff, 32'h8000_0000);
    store(32'h0, 32'h0);
    store(32'hffff_ffff, 32'hffff_ffff);
    lookup(32'h8000_0000);
    lookup(32'h7fff_ffff);
    lookup(32'h0);
    lookup(32'hffff_ffff);
    store(32'h0, 32'ha5a5_5a5a);
    lookup(32'h0);
    lookup(32'h1);

    // shrink below the fill: only the most recent entry survives
    set_capacity(5'd1);
    lookup(32'h0);
    lookup(32'hffff_ffff);
    store(32'h7, 32'h1234_5678);
    lookup(32'h0);
    lookup(32'h7);

    // zero capacity behaves as one
    set_capacity(5'd0);
    store(32'h8, 32'hdead_beef);
    lookup(32'h7);
    lookup(32'h8);

    // a write to an unmapped register changes nothing
    drain();
    reg_write({~REG_ACTIVE_ENTRIES, 2'($urandom())}, $urandom());
    store(32'h9, 32'h0bad_f00d);
    lookup(32'h8);
    lookup(32'h9);

    set_capacity(5'd16);
    run_phase(MAX_ENTRIES);
    foreach (settings[i]) begin
      set_capacity(settings[i]);
      eff = (settings[i] == 0) ? 1 : (settings[i] > MAX_ENTRIES ? MAX_ENTRIES
                                                                 : settings[i]);
      run_phase(eff);
    end

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
